// ----- rtl/core/stsc_pkg.sv -----
// ----------------------------------------------------------------------------
// stsc_pkg
// shared types and constants of the segment tree sum/count block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stsc_pkg;

  localparam int unsigned LEAVES_DEF = 1024;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned LEAF_W     = 10;
  localparam int unsigned RANGE_W    = 11;
  localparam int unsigned AMT_W      = 32;

  typedef enum logic {
    MODE_ADD   = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_ADD_WB,
    ST_QUERY,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } node_t;

endpackage

// ----- rtl/core/stsc_if.sv -----
// ----------------------------------------------------------------------------
// stsc_if
// request and response channels of the segment tree sum/count block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stsc_req_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [stsc_pkg::LEAF_W-1:0]       leaf_index;
  logic signed [stsc_pkg::AMT_W-1:0] add_amount;
  logic                              count_up;
  logic [stsc_pkg::RANGE_W-1:0]      range_start;
  logic [stsc_pkg::RANGE_W-1:0]      range_end;

  modport source (
    output valid, mode, leaf_index, add_amount, count_up, range_start, range_end,
    input  ready
  );
  modport sink (
    input  valid, mode, leaf_index, add_amount, count_up, range_start, range_end,
    output ready
  );
endinterface

interface stsc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [stsc_pkg::SUM_W-1:0] range_sum;
  logic signed [stsc_pkg::CNT_W-1:0] range_count;

  modport source (
    output valid, range_sum, range_count,
    input  ready
  );
  modport sink (
    input  valid, range_sum, range_count,
    output ready
  );
endinterface

// ----- rtl/core/stsc_node_ram.sv -----
// ----------------------------------------------------------------------------
// stsc_node_ram
// tree node store, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stsc_node_ram #(
  parameter int unsigned ADDR_W = 11
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  stsc_pkg::node_t     wdata_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output stsc_pkg::node_t     rdata_o
);

  stsc_pkg::node_t mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/stsc_adder.sv -----
// ----------------------------------------------------------------------------
// stsc_adder
// shared node adder, wrapping sum and count lanes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stsc_adder (
  input  stsc_pkg::node_t a_i,
  input  stsc_pkg::node_t b_i,
  output stsc_pkg::node_t sum_o
);

  assign sum_o.sum = a_i.sum + b_i.sum;
  assign sum_o.cnt = a_i.cnt + b_i.cnt;

endmodule

// ----- rtl/core/segment_tree_sum_count_top.sv -----
// ----------------------------------------------------------------------------
// segment_tree_sum_count_top
// point-update, range-sum segment tree over sum and count nodes
// add item: one tree level per cycle through the node ram
// query item: at most one node read per cycle
// one item at a time; a query also holds while the previous result item waits
// after reset a clearing pass writes all 2*span nodes, one per cycle, not ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_tree_sum_count_top #(
  parameter int unsigned LEAVES = stsc_pkg::LEAVES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stsc_req_if.sink    req_i,
  stsc_rsp_if.source  rsp_o
);

  localparam int unsigned LVL_W   = $clog2(LEAVES);
  localparam int unsigned NODE_W  = LVL_W + 1;
  localparam int unsigned PTR_W   = NODE_W + 1;
  localparam logic [31:0] SPAN    = 32'(1) << LVL_W;
  localparam logic [31:0] LEAF_N  = 32'(LEAVES);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(SPAN << 1);

  stsc_pkg::state_e state_q, state_d;

  logic [NODE_W-1:0] node_q, node_d;
  logic [NODE_W-1:0] clr_q, clr_d;
  logic [NODE_W-1:0] waddr_q, waddr_d;
  logic [PTR_W-1:0]  l_q, l_d;
  logic [PTR_W-1:0]  r_q, r_d;
  logic              rd_pend_q, rd_pend_d;
  logic              out_valid_q, out_valid_d;
  stsc_pkg::node_t   delta_q, delta_d;
  stsc_pkg::node_t   acc_q, acc_d;
  stsc_pkg::node_t   out_q, out_d;

  logic              ram_we;
  logic [NODE_W-1:0] ram_waddr;
  logic [NODE_W-1:0] ram_raddr;
  stsc_pkg::node_t   ram_wdata;
  stsc_pkg::node_t   ram_rdata;

  logic              is_add;
  stsc_pkg::node_t   add_a, add_b, add_sum;

  logic [31:0]       lo_ext, hi_ext, lo_clamp, hi_clamp, l_start, r_start;
  logic [31:0]       leaf_ext, leaf_node;
  logic [PTR_W-1:0]  l_inc, r_dec;

  stsc_node_ram #(
    .ADDR_W (NODE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign is_add = (state_q == stsc_pkg::ST_ADD) || (state_q == stsc_pkg::ST_ADD_WB);

  always_comb begin
    if (is_add) begin
      add_a = ram_rdata;
      add_b = delta_q;
    end else begin
      add_a = acc_q;
      add_b = ram_rdata;
    end
  end

  stsc_adder u_adder (
    .a_i   (add_a),
    .b_i   (add_b),
    .sum_o (add_sum)
  );

  // range clamping and leaf placement
  assign lo_ext    = 32'(req_i.range_start);
  assign hi_ext    = 32'(req_i.range_end);
  assign lo_clamp  = (lo_ext > LEAF_N) ? LEAF_N : lo_ext;
  assign hi_clamp  = (hi_ext > LEAF_N) ? LEAF_N : hi_ext;
  assign l_start   = lo_clamp + SPAN;
  assign r_start   = hi_clamp + SPAN;
  assign leaf_ext  = 32'(req_i.leaf_index);
  assign leaf_node = leaf_ext + SPAN;
  assign l_inc     = l_q + PTR_W'(1);
  assign r_dec     = r_q - PTR_W'(1);

  always_comb begin
    state_d     = state_q;
    node_d      = node_q;
    clr_d       = clr_q;
    waddr_d     = waddr_q;
    l_d         = l_q;
    r_d         = r_q;
    rd_pend_d   = 1'b0;
    delta_d     = delta_q;
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = waddr_q;
    ram_wdata   = add_sum;
    ram_raddr   = node_q;
    req_i.ready = (state_q == stsc_pkg::ST_IDLE);

    if (rd_pend_q) begin
      if (is_add) begin
        ram_we = 1'b1;
      end else begin
        acc_d = add_sum;
      end
    end

    case (state_q)
      stsc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + NODE_W'(1);
        if (clr_q == '1) begin
          state_d = stsc_pkg::ST_IDLE;
        end
      end
      stsc_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.mode == stsc_pkg::MODE_QUERY) begin
            l_d     = l_start[PTR_W-1:0];
            r_d     = r_start[PTR_W-1:0];
            acc_d   = '0;
            state_d = stsc_pkg::ST_QUERY;
          end else if (leaf_ext < LEAF_N) begin
            node_d        = leaf_node[NODE_W-1:0];
            delta_d.sum   = {
              {(stsc_pkg::SUM_W - stsc_pkg::AMT_W){req_i.add_amount[stsc_pkg::AMT_W-1]}},
              req_i.add_amount
            };
            delta_d.cnt   = req_i.count_up ? stsc_pkg::CNT_W'(1) : '1;
            state_d       = stsc_pkg::ST_ADD;
          end
        end
      end
      stsc_pkg::ST_ADD: begin
        ram_raddr = node_q;
        rd_pend_d = 1'b1;
        waddr_d   = node_q;
        node_d    = node_q >> 1;
        if (node_q == NODE_W'(1)) begin
          state_d = stsc_pkg::ST_ADD_WB;
        end
      end
      stsc_pkg::ST_ADD_WB: begin
        state_d = stsc_pkg::ST_IDLE;
      end
      stsc_pkg::ST_QUERY: begin
        if (l_q < r_q) begin
          if (l_q[0]) begin
            ram_raddr = l_q[NODE_W-1:0];
            rd_pend_d = 1'b1;
            if (r_q[0]) begin
              l_d = l_inc;
            end else begin
              l_d = l_inc >> 1;
              r_d = r_q >> 1;
            end
          end else if (r_q[0]) begin
            ram_raddr = r_dec[NODE_W-1:0];
            rd_pend_d = 1'b1;
            r_d       = r_dec >> 1;
            l_d       = l_q >> 1;
          end else begin
            l_d = l_q >> 1;
            r_d = r_q >> 1;
          end
        end else begin
          state_d = stsc_pkg::ST_DRAIN;
        end
      end
      stsc_pkg::ST_DRAIN: begin
        state_d = stsc_pkg::ST_RESULT;
      end
      stsc_pkg::ST_RESULT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = acc_q;
          out_valid_d = 1'b1;
          state_d     = stsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stsc_pkg::ST_CLEAR;
      clr_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    waddr_q <= waddr_d;
    l_q     <= l_d;
    r_q     <= r_d;
    delta_q <= delta_d;
    acc_q   <= acc_d;
    out_q   <= out_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.range_sum   = $signed(out_q.sum);
  assign rsp_o.range_count = $signed(out_q.cnt);

  // no item taken while the node store is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stsc_pkg::ST_CLEAR) |-> !req_i.ready)
    else $error("item accepted during clearing pass");

  // path updates never touch the unused slot zero
  a_add_wr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && is_add) |-> (ram_waddr != '0))
    else $error("add wrote node slot zero");

  // query window bounds never exceed 2*span, one past the last node
  a_query_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == stsc_pkg::ST_QUERY) |-> ((l_q <= PTR_MAX) && (r_q <= PTR_MAX)))
    else $error("query bounds outside node space");

  // a pending read always stems from an add or query step
  a_pend_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ($past(state_q) == stsc_pkg::ST_ADD || $past(state_q) == stsc_pkg::ST_QUERY))
    else $error("read pending without a walk step");

  // a result item only follows a finished query
  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == stsc_pkg::ST_RESULT))
    else $error("result item raised outside result state");

endmodule
